[src/hse_pkg.sv]
// Package: shared types, constants and SHA-1 helper functions for the HMAC-SHA1 engine.
`timescale 1ns / 1ps
`default_nettype none
package hse_pkg;
   localparam int BLOCK_BYTES = 64;
   localparam int NUM_KEY_WORDS = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam logic [31:0] IPAD_WORD = 32'h36363636;
   localparam logic [31:0] OPAD_WORD = 32'h5c5c5c5c;
   localparam logic [159:0] SHA1_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                       32'h10325476, 32'hC3D2E1F0};

   typedef struct packed {
      logic       start;
      logic       has_byte;
      logic [7:0] data_byte;
      logic       is_last;
   } cmd_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
   } regs_type;

   function automatic logic [31:0] round_k(input logic [6:0] r);
      logic [31:0] k;
      if (r < 7'd20) k = 32'h5A827999;
      else if (r < 7'd40) k = 32'h6ED9EBA1;
      else if (r < 7'd60) k = 32'h8F1BBCDC;
      else k = 32'hCA62C1D6;
      return k;
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (r < 7'd20) f = (b & c) | (~b & d);
      else if (r < 7'd40) f = b ^ c ^ d;
      else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
      else f = b ^ c ^ d;
      return f;
   endfunction
endpackage
`default_nettype wire

[src/hse_sha1_core.sv]
// SHA-1 compression unit: one round per cycle over a 16-word rolling schedule.
`timescale 1ns / 1ps
`default_nettype none
module hse_sha1_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [159:0] h_in,
   input  wire logic [511:0] block,
   output logic              done,
   output logic [159:0]      h_out
);
   logic [511:0] w_ff, w_in;
   hse_pkg::regs_type v_ff, v_in;
   logic [159:0] h_ff, h_in_r;
   logic [6:0] r_ff, r_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [31:0] wt, wnew, t;

   assign wt = w_ff[511:480];
   assign wnew = {w_ff[95:64] ^ w_ff[255:224] ^ w_ff[447:416] ^ w_ff[511:480]}
                 << 1 | {w_ff[95:64] ^ w_ff[255:224] ^ w_ff[447:416] ^ w_ff[511:480]} >> 31;
   assign t = {v_ff.a[26:0], v_ff.a[31:27]} + hse_pkg::round_f(r_ff, v_ff.b, v_ff.c, v_ff.d)
              + v_ff.e + hse_pkg::round_k(r_ff) + wt;

   always_comb begin
      w_in = w_ff; v_in = v_ff; h_in_r = h_ff; r_in = r_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         w_in = block; h_in_r = h_in; v_in = h_in; r_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         w_in = {w_ff[479:0], wnew};
         v_in.a = t; v_in.b = v_ff.a; v_in.c = {v_ff.b[1:0], v_ff.b[31:2]};
         v_in.d = v_ff.c; v_in.e = v_ff.d;
         r_in = r_ff + 7'd1;
         if (r_ff == 7'd79) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in; v_ff <= v_in; h_ff <= h_in_r; r_ff <= r_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign h_out = {h_ff[159:128] + v_ff.a, h_ff[127:96] + v_ff.b, h_ff[95:64] + v_ff.c,
                   h_ff[63:32] + v_ff.d, h_ff[31:0] + v_ff.e};
endmodule
`default_nettype wire

[src/hse_front.sv]
// Front end: accepts request beats, marks message starts, queues commands.
`timescale 1ns / 1ps
`default_nettype none
module hse_front #(
   parameter int QUEUE_DEPTH = hse_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_byte_valid,
   input  wire logic             req_is_last,
   output logic                  cmd_valid,
   input  wire logic             cmd_take,
   output hse_pkg::cmd_type      cmd
);
   localparam int AW = $clog2(QUEUE_DEPTH);
   hse_pkg::cmd_type q_ff [QUEUE_DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff;
   logic started_ff;
   logic push;

   assign req_stall = (cnt_ff == (AW+1)'(QUEUE_DEPTH));
   assign push = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= '{start: !started_ff, has_byte: req_byte_valid,
                                 data_byte: req_data_byte, is_last: req_is_last};
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0; started_ff <= 1'b0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + 1'b1;
            started_ff <= !req_is_last;
         end
         if (cmd_take) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(cmd_take);
      end
   end
endmodule
`default_nettype wire

[src/hse_back.sv]
// Back end: block assembly, padding, inner/outer hashing and digest word output.
`timescale 1ns / 1ps
`default_nettype none
module hse_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [511:0]     key,
   input  wire logic             cmd_valid,
   output logic                  cmd_take,
   input  wire hse_pkg::cmd_type cmd,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [31:0]           rsp_digest_word,
   output logic [2:0]            rsp_word_index,
   output logic                  rsp_last_word
);
   typedef enum logic [3:0] {
      S_IDLE, S_IPAD, S_BYTE, S_PAD, S_HASH, S_OPAD, S_OUTER, S_EMIT
   } state_type;

   state_type st_ff;
   hse_pkg::cmd_type c_ff;
   logic [511:0] buf_ff;
   logic [5:0] pos_ff;
   logic [63:0] len_ff;
   logic [159:0] ch_ff, inner_ff;
   logic padding_ff, waiting_ff, lenput_ff;
   logic [2:0] idx_ff;
   logic core_start;
   logic [159:0] core_h;
   logic [511:0] core_blk;
   logic core_done;
   logic [159:0] core_out;
   logic [7:0] pbyte;
   logic [511:0] kblk;

   hse_sha1_core u_core (.clock(clock), .reset(reset), .start(core_start), .h_in(core_h),
                         .block(core_blk), .done(core_done), .h_out(core_out));

   assign cmd_take = (st_ff == S_IDLE) && cmd_valid;
   assign rsp_valid = (st_ff == S_EMIT);
   assign rsp_digest_word = ch_ff[159:128];
   assign rsp_word_index = idx_ff;
   assign rsp_last_word = (idx_ff == 3'd4);

   always_comb begin
      kblk = key ^ {16{(st_ff == S_IDLE) ? hse_pkg::IPAD_WORD : hse_pkg::OPAD_WORD}};
      core_start = 1'b0; core_h = ch_ff; core_blk = buf_ff;
      if (st_ff == S_IDLE && cmd_valid && cmd.start) begin
         core_start = 1'b1; core_h = hse_pkg::SHA1_IV; core_blk = kblk;
      end else if (st_ff == S_HASH && !waiting_ff) begin
         core_start = 1'b1;
      end else if (st_ff == S_OPAD && !waiting_ff) begin
         core_start = 1'b1; core_h = hse_pkg::SHA1_IV; core_blk = kblk;
      end else if (st_ff == S_OUTER && !waiting_ff) begin
         core_start = 1'b1;
         core_blk = {inner_ff, 32'h80000000, 288'd0, 32'd672};
      end
      if (!padding_ff) pbyte = 8'h80;
      else if (lenput_ff) pbyte = len_ff[63:56];
      else pbyte = 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; buf_ff <= '0; pos_ff <= '0; len_ff <= 64'd512;
         ch_ff <= hse_pkg::SHA1_IV; padding_ff <= 1'b0; waiting_ff <= 1'b0;
         lenput_ff <= 1'b0; idx_ff <= '0;
      end else begin
         unique case (st_ff)
            S_IDLE: if (cmd_valid) begin
               c_ff <= cmd;
               if (cmd.start) begin
                  st_ff <= S_IPAD; len_ff <= 64'd512;
               end else st_ff <= S_BYTE;
            end
            S_IPAD: if (core_done) begin
               ch_ff <= core_out; st_ff <= S_BYTE;
            end
            S_BYTE: begin
               if (c_ff.has_byte) begin
                  buf_ff[(6'd63 - pos_ff)*8 +: 8] <= c_ff.data_byte;
                  pos_ff <= pos_ff + 6'd1;
                  len_ff <= len_ff + 64'd8;
                  c_ff.has_byte <= 1'b0;
                  if (pos_ff == 6'd63) begin
                     st_ff <= S_HASH; waiting_ff <= 1'b0;
                  end
               end else if (c_ff.is_last) begin
                  st_ff <= S_PAD; padding_ff <= 1'b0; lenput_ff <= 1'b0;
               end else st_ff <= S_IDLE;
            end
            S_PAD: begin
               buf_ff[(6'd63 - pos_ff)*8 +: 8] <= pbyte;
               pos_ff <= pos_ff + 6'd1;
               if (lenput_ff) len_ff <= {len_ff[55:0], 8'h00};
               if (!padding_ff) padding_ff <= 1'b1;
               if (pos_ff == 6'd55) lenput_ff <= 1'b1;
               if (pos_ff == 6'd63) begin
                  st_ff <= S_HASH; waiting_ff <= 1'b0;
               end
            end
            S_HASH: begin
               waiting_ff <= 1'b1;
               if (core_done) begin
                  ch_ff <= core_out; buf_ff <= '0; waiting_ff <= 1'b0;
                  if (!c_ff.is_last) st_ff <= S_BYTE;
                  else if (padding_ff && lenput_ff && pos_ff == 6'd0) begin
                     inner_ff <= core_out; st_ff <= S_OPAD;
                  end else st_ff <= S_PAD;
               end
            end
            S_OPAD: begin
               waiting_ff <= 1'b1;
               if (core_done) begin
                  ch_ff <= core_out; waiting_ff <= 1'b0; st_ff <= S_OUTER;
               end
            end
            S_OUTER: begin
               waiting_ff <= 1'b1;
               if (core_done) begin
                  ch_ff <= core_out; waiting_ff <= 1'b0; st_ff <= S_EMIT; idx_ff <= '0;
               end
            end
            S_EMIT: if (!rsp_stall) begin
               ch_ff <= {ch_ff[127:0], 32'd0};
               idx_ff <= idx_ff + 3'd1;
               if (idx_ff == 3'd4) begin
                  st_ff <= S_IDLE; ch_ff <= hse_pkg::SHA1_IV; buf_ff <= '0;
                  pos_ff <= '0; len_ff <= 64'd512; padding_ff <= 1'b0;
                  lenput_ff <= 1'b0;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

[src/hmac_sha1_engine_unit.sv]
// Top level: HMAC-SHA1 engine with key registers, command front end and hash back end.
// Usage: write the key through csr_write/csr_index/csr_data (indexes 0..7, 64 bits each,
// big-endian key bytes, zero padded) while the block is idle. Send message bytes on the
// req_ channel: req_byte_valid marks a message byte, req_is_last ends the message.
// A beat is taken when req_valid is high and req_stall low; a four-entry command queue
// lets the front keep taking beats while the back end hashes.
// The first beat of a message hashes the ipad block; message bytes then fill 64-byte
// blocks, and each full block is hashed by the single one-round-per-cycle SHA-1 core,
// which is the limit. The last beat adds padding, one or two inner blocks and two outer
// blocks, then five rsp_ beats carry the digest words, index 0 first, rsp_last_word on
// the fifth. rsp_stall holds the current word. Reset clears the key to zero and the
// hash state to its start.
`timescale 1ns / 1ps
`default_nettype none
module hmac_sha1_engine_unit #(
   parameter int QUEUE_DEPTH = hse_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_valid,
   input  wire logic        req_is_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);
   logic [63:0] key_ff [hse_pkg::NUM_KEY_WORDS];
   logic [511:0] key;
   logic cmd_valid, cmd_take;
   hse_pkg::cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hse_pkg::NUM_KEY_WORDS; i++) key_ff[i] <= '0;
      end else if (csr_write) begin
         key_ff[csr_index] <= csr_data;
      end
   end

   always_comb begin
      for (int i = 0; i < hse_pkg::NUM_KEY_WORDS; i++) key[511 - 64*i -: 64] = key_ff[i];
   end

   hse_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_data_byte(req_data_byte), .req_byte_valid(req_byte_valid),
      .req_is_last(req_is_last), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd));

   hse_back u_back (
      .clock(clock), .reset(reset), .key(key), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
      .cmd(cmd), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word));
endmodule
`default_nettype wire

[test/tb_hmac_sha1_engine_unit.sv]
// Testbench: drives byte messages into the HMAC-SHA1 engine and checks each digest word.
`timescale 1ns / 1ps
`default_nettype none
module tb_hmac_sha1_engine_unit;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int RANDOM_ITEMS = 450;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_beat_type;

   typedef struct {
      logic         byte_valid;
      logic [7:0]   data;
      logic         is_last;
      logic         has_digest;
      logic [159:0] digest;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_byte_valid;
   logic        req_is_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   hmac_sha1_engine_unit uut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_data_byte(req_data_byte),
      .req_byte_valid(req_byte_valid), .req_is_last(req_is_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_digest_word(rsp_digest_word),
      .rsp_word_index(rsp_word_index), .rsp_last_word(rsp_last_word)
   );

   // model state
   logic [63:0]  key_regs [hse_pkg::NUM_KEY_WORDS];
   logic [159:0] chain;
   logic [511:0] msg_block;
   int           byte_pos;
   logic [63:0]  bit_count;
   logic         ipad_done;

   digest_beat_type digest_q[$];
   int  errors = 0;
   int  cycles = 0;
   int  items_sent = 0;
   logic send_calm = 0;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [159:0] sha1_compress(input logic [159:0] h,
                                                  input logic [511:0] blk);
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
      for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      {a, b, c, d, e} = h;
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d); k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d; k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d; k = 32'hCA62C1D6;
         end
         t = rotl(a, 5) + f + e + k + w[i];
         e = d; d = c; c = rotl(b, 30); b = a; a = t;
      end
      return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
   endfunction

   function automatic logic [511:0] padded_key(input logic [31:0] pad);
      logic [511:0] kb;
      for (int i = 0; i < hse_pkg::NUM_KEY_WORDS; i++)
         kb[511 - 64 * i -: 64] = key_regs[i] ^ {pad, pad};
      return kb;
   endfunction

   task automatic absorb_byte(input logic [7:0] v);
      msg_block[511 - 8 * byte_pos -: 8] = v;
      byte_pos++;
      if (byte_pos == hse_pkg::BLOCK_BYTES) begin
         chain = sha1_compress(chain, msg_block);
         msg_block = '0;
         byte_pos = 0;
      end
   endtask

   task automatic clear_inner();
      chain = hse_pkg::SHA1_IV;
      msg_block = '0;
      byte_pos = 0;
      bit_count = '0;
      ipad_done = 0;
   endtask

   // advances the model by one beat; returns the HMAC when the beat ends a message
   task automatic hmac_step(input logic bv, input logic [7:0] d, input logic l,
                            output logic done, output logic [159:0] mac);
      logic [63:0]  len;
      logic [159:0] outer;
      done = 0;
      mac = '0;
      if (!ipad_done) begin
         chain = sha1_compress(chain, padded_key(hse_pkg::IPAD_WORD));
         msg_block = '0;
         byte_pos = 0;
         bit_count = 64'd512;
         ipad_done = 1;
      end
      if (bv) begin
         absorb_byte(d);
         bit_count += 64'd8;
      end
      if (l) begin
         len = bit_count;
         absorb_byte(8'h80);
         while (byte_pos != hse_pkg::BLOCK_BYTES - 8) absorb_byte(8'h00);
         for (int i = 0; i < 8; i++) absorb_byte(len[63 - 8 * i -: 8]);
         outer = sha1_compress(hse_pkg::SHA1_IV, padded_key(hse_pkg::OPAD_WORD));
         mac = sha1_compress(outer, {chain, 32'h80000000, 288'h0, 32'd672});
         done = 1;
         clear_inner();
      end
   endtask

   task automatic push_digest(input logic [159:0] mac);
      digest_beat_type beat;
      for (int i = 0; i < 5; i++) begin
         beat.word = mac[159 - 32 * i -: 32];
         beat.index = i[2:0];
         beat.last = (i == 4);
         digest_q.push_back(beat);
      end
   endtask

   task automatic send_beat(input logic bv, input logic [7:0] d, input logic l,
                            input logic typed, input logic [159:0] typed_mac);
      logic acc;
      logic done;
      logic [159:0] mac;
      while (!send_calm && $urandom_range(99) < 11) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_byte_valid <= bv;
      req_data_byte <= d;
      req_is_last <= l;
      acc = 0;
      while (!acc) begin
         @(negedge clock);
         acc = !req_stall;
         @(posedge clock);
      end
      hmac_step(bv, d, l, done, mac);
      if (done) push_digest(typed ? typed_mac : mac);
      items_sent++;
      if (items_sent == 200) send_calm = 1;
      if (items_sent == 320) send_calm = 0;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (digest_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic load_key(input logic [63:0] k [hse_pkg::NUM_KEY_WORDS]);
      for (int i = 0; i < hse_pkg::NUM_KEY_WORDS; i++) begin
         csr_write <= 1;
         csr_index <= i[2:0];
         csr_data <= k[i];
         key_regs[i] = k[i];
         @(posedge clock);
      end
      csr_write <= 0;
      @(posedge clock);
   endtask

   task automatic random_message();
      int len;
      logic lb;
      case ($urandom_range(9))
         0: len = 55;
         1: len = 56;
         2: len = 63 + $urandom_range(1);
         3: len = 119 + $urandom_range(1);
         4: len = $urandom_range(200);
         default: len = $urandom_range(40);
      endcase
      lb = 1'($urandom_range(1));
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(19) == 0) send_beat(0, 8'($urandom_range(255)), 0, 0, '0);
         send_beat(1, 8'($urandom_range(255)), 0, 0, '0);
      end
      send_beat(lb, 8'($urandom_range(255)), 1, 0, '0);
   endtask

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock)
      if (reset) rsp_stall <= 0;
      else if (cycles > 30000 && cycles < 45000) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(99) < 11);

   always @(negedge clock) begin
      digest_beat_type exp_beat;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_q.size() == 0) begin
            $display("%0t: unexpected digest beat %h idx %0d", $time, rsp_digest_word,
                     rsp_word_index);
            errors++;
         end else begin
            exp_beat = digest_q.pop_front();
            if (rsp_digest_word !== exp_beat.word || rsp_word_index !== exp_beat.index ||
                rsp_last_word !== exp_beat.last) begin
               $display("%0t: expected %h/%0d/%b got %h/%0d/%b", $time, exp_beat.word,
                        exp_beat.index, exp_beat.last, rsp_digest_word, rsp_word_index,
                        rsp_last_word);
               errors++;
            end
         end
      end
   end

   stim_row_type dir_rows [] = '{
      '{0, 8'h00, 1, 1, 160'hfbdb1d1b18aa6c08324b7d64b71fb76370690e1d},
      '{0, 8'h00, 0, 0, '0},
      '{0, 8'h00, 1, 1, 160'hfbdb1d1b18aa6c08324b7d64b71fb76370690e1d},
      '{1, 8'h00, 1, 0, '0},
      '{1, 8'hff, 1, 0, '0},
      '{1, 8'h61, 0, 0, '0},
      '{1, 8'h62, 0, 0, '0},
      '{0, 8'hff, 0, 0, '0},
      '{1, 8'h63, 1, 0, '0},
      '{1, 8'h80, 0, 0, '0},
      '{1, 8'h01, 0, 0, '0},
      '{0, 8'h55, 1, 0, '0},
      '{1, 8'haa, 0, 0, '0},
      '{1, 8'h7f, 1, 0, '0}
   };

   initial begin
      logic [63:0] k [hse_pkg::NUM_KEY_WORDS];
      int phase;
      reset = 1;
      csr_write = 0;
      csr_index = '0;
      csr_data = '0;
      req_valid = 0;
      req_data_byte = '0;
      req_byte_valid = 0;
      req_is_last = 0;
      for (int i = 0; i < hse_pkg::NUM_KEY_WORDS; i++) key_regs[i] = '0;
      clear_inner();
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_beat(dir_rows[i].byte_valid, dir_rows[i].data, dir_rows[i].is_last,
                   dir_rows[i].has_digest, dir_rows[i].digest);
      drain();

      items_sent = 0;
      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= phase * 90) begin
            drain();
            for (int i = 0; i < hse_pkg::NUM_KEY_WORDS; i++)
               case (phase % 5)
                  0: k[i] = '1;
                  1: k[i] = {$urandom, $urandom};
                  2: k[i] = (i < 2) ? {$urandom, $urandom} : 64'h0;
                  3: k[i] = 64'h0;
                  default: k[i] = (i % 2) ? 64'haaaa5555aaaa5555 : 64'h5555aaaa5555aaaa;
               endcase
            load_key(k);
            phase++;
         end
         random_message();
      end
      drain();
      repeat (50) @(posedge clock);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

[filelist.f]
src/hse_pkg.sv
src/hse_sha1_core.sv
src/hse_front.sv
src/hse_back.sv
src/hmac_sha1_engine_unit.sv
test/tb_hmac_sha1_engine_unit.sv
